// ===== sv/dpt_pkg.sv =====
// package for density point thinning: sizes, controller states and
// the command and status structs between controller and datapath
// no dependencies
`default_nettype none
package dpt_pkg;
   localparam int MaxPoints  = 64;
   localparam int IdxW       = $clog2(MaxPoints);
   localparam int TotW       = $clog2(MaxPoints + 1);
   localparam int CoordW     = 16;
   localparam int LayerW     = 4;
   localparam int CntW       = 6;
   localparam int RadW       = 12;
   localparam int CsrIdxW    = 1;
   localparam int CsrDataW   = 12;
   localparam logic [CsrIdxW-1:0] CSR_RADIUS = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_MAXCNT = 1'd1;
   localparam logic [CntW-1:0] CountMax = '1;

   typedef enum logic [2:0] {
      ST_LOAD, ST_PAIR, ST_SORT, ST_VISIT, ST_DEC, ST_EMIT
   } state_type;

   typedef struct packed {
      logic            load;     // write req point at load index
      logic            clr_nbr;  // clear neighbour row i before pair sweep
      logic            pair;     // compare point i with point j
      logic            pair_end; // store count of row i
      logic            sort;     // append i to order if count == c
      logic            visit;    // read order[k], test removal
      logic            dec;      // decrement neighbour j of victim
      logic            emit;     // present point i
      logic            emit_last;
      logic [IdxW-1:0] i;
      logic [IdxW-1:0] j;
      logic [CntW-1:0] c;
      logic [IdxW-1:0] k;
   } cmd_type;

   typedef struct packed {
      logic            remove;   // visited point becomes removed
      logic [IdxW-1:0] victim;
   } stat_type;
endpackage
`default_nettype wire

// ===== sv/dpt_datapath.sv =====
// datapath: point store, neighbour matrix, counts, visit order
// depends on dpt_pkg
`default_nettype none
module dpt_datapath import dpt_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   output stat_type                      stat,
   input  wire logic [IdxW-1:0]          load_idx,
   input  wire logic signed [CoordW-1:0] req_x,
   input  wire logic signed [CoordW-1:0] req_y,
   input  wire logic signed [CoordW-1:0] req_z,
   input  wire logic [LayerW-1:0]        req_layer,
   input  wire logic [RadW-1:0]          radius,
   input  wire logic [CntW-1:0]          max_cnt,
   input  wire logic                     overflow_seen,
   output logic                          rsp_valid,
   output logic signed [CoordW-1:0]      rsp_out_x,
   output logic signed [CoordW-1:0]      rsp_out_y,
   output logic signed [CoordW-1:0]      rsp_out_z,
   output logic [LayerW-1:0]             rsp_out_layer,
   output logic                          rsp_keep,
   output logic                          rsp_overflow,
   output logic                          rsp_out_last
);
   logic signed [CoordW-1:0] px_ff [MaxPoints];
   logic signed [CoordW-1:0] py_ff [MaxPoints];
   logic signed [CoordW-1:0] pz_ff [MaxPoints];
   logic [LayerW-1:0]        pl_ff [MaxPoints];
   logic [MaxPoints-1:0]     nbr_ff [MaxPoints];
   logic [CntW-1:0]          base_ff [MaxPoints];
   logic [CntW-1:0]          eff_ff [MaxPoints];
   logic [MaxPoints-1:0]     removed_ff;
   logic [IdxW-1:0]          order_ff [MaxPoints];
   logic [IdxW-1:0]          ord_n_ff;
   logic [CntW-1:0]          acc_ff;
   logic [MaxPoints-1:0]     row_ff;

   // registered read data, addressed by the command of the previous cycle, or for eff_v_ff and row_v_ff by vp_ff
   logic signed [CoordW-1:0] xi_ff, yi_ff, zi_ff, xj_ff, yj_ff, zj_ff;
   logic [LayerW-1:0]        li_ff;
   logic [CntW-1:0]          base_rd_ff, eff_v_ff, eff_j_ff;
   logic [IdxW-1:0]          vp_ff;
   logic [MaxPoints-1:0]     row_v_ff;
   logic [2*CoordW+1:0]      sqx_ff, sqy_ff, sqz_ff;
   logic [2*RadW-1:0]        r2_ff;

   // one pair per sweep step: read, square, then sum and compare
   logic signed [CoordW:0]   dx, dy, dz;
   logic [2*CoordW+1:0]      d2;
   logic                     hit;
   logic [CntW-1:0]          acc_sum;
   logic [MaxPoints-1:0]     row_sum;
   always_comb begin
      dx  = {xi_ff[CoordW-1], xi_ff} - {xj_ff[CoordW-1], xj_ff};
      dy  = {yi_ff[CoordW-1], yi_ff} - {yj_ff[CoordW-1], yj_ff};
      dz  = {zi_ff[CoordW-1], zi_ff} - {zj_ff[CoordW-1], zj_ff};
      d2  = sqx_ff + sqy_ff + sqz_ff;
      hit = (cmd.i != cmd.j) && (d2 <= (2*CoordW+2)'(r2_ff));
      acc_sum = (hit && acc_ff != CountMax) ? acc_ff + 1'b1 : acc_ff;
      row_sum = row_ff;
      row_sum[cmd.j] = row_ff[cmd.j] | hit;
      stat.remove = cmd.visit && !removed_ff[vp_ff] && (eff_v_ff > max_cnt);
      stat.victim = vp_ff;
   end

   always_ff @(posedge clock) begin
      xi_ff      <= px_ff[cmd.i];
      yi_ff      <= py_ff[cmd.i];
      zi_ff      <= pz_ff[cmd.i];
      li_ff      <= pl_ff[cmd.i];
      xj_ff      <= px_ff[cmd.j];
      yj_ff      <= py_ff[cmd.j];
      zj_ff      <= pz_ff[cmd.j];
      base_rd_ff <= base_ff[cmd.i];
      vp_ff      <= order_ff[cmd.k];
      eff_v_ff   <= eff_ff[vp_ff];
      eff_j_ff   <= eff_ff[cmd.j];
      row_v_ff   <= nbr_ff[vp_ff];
      sqx_ff     <= unsigned'((2*CoordW+2)'(dx) * (2*CoordW+2)'(dx));
      sqy_ff     <= unsigned'((2*CoordW+2)'(dy) * (2*CoordW+2)'(dy));
      sqz_ff     <= unsigned'((2*CoordW+2)'(dz) * (2*CoordW+2)'(dz));
      r2_ff      <= radius * radius;
      if (cmd.load) begin
         px_ff[load_idx] <= req_x;
         py_ff[load_idx] <= req_y;
         pz_ff[load_idx] <= req_z;
         pl_ff[load_idx] <= req_layer;
      end
      if (cmd.clr_nbr) begin
         acc_ff <= '0;
         row_ff <= '0;
      end else if (cmd.pair) begin
         acc_ff <= acc_sum;
         row_ff <= row_sum;
      end
      // the last column of the row is folded in here
      if (cmd.pair_end) begin
         nbr_ff[cmd.i]  <= row_sum;
         base_ff[cmd.i] <= acc_sum;
         eff_ff[cmd.i]  <= acc_sum;
      end
      if (cmd.sort && base_rd_ff == cmd.c) order_ff[ord_n_ff] <= cmd.i;
      if (cmd.dec && row_v_ff[cmd.j] && !removed_ff[cmd.j] && eff_j_ff != '0) begin
         eff_ff[cmd.j] <= eff_j_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         removed_ff <= '0;
         ord_n_ff   <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         if (cmd.pair_end) removed_ff[cmd.i] <= 1'b0;
         if (stat.remove) removed_ff[vp_ff] <= 1'b1;
         if (cmd.pair_end) ord_n_ff <= '0;
         else if (cmd.sort && base_rd_ff == cmd.c) ord_n_ff <= ord_n_ff + 1'b1;
         rsp_valid <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_x     <= xi_ff;
      rsp_out_y     <= yi_ff;
      rsp_out_z     <= zi_ff;
      rsp_out_layer <= li_ff;
      rsp_keep      <= !removed_ff[cmd.i];
      rsp_overflow  <= overflow_seen;
      rsp_out_last  <= cmd.emit_last;
   end
endmodule
`default_nettype wire

// ===== sv/dpt_ctrl.sv =====
// controller: load counting, pair sweep, counting sort, greedy visit, emit
// depends on dpt_pkg
`default_nettype none
module dpt_ctrl import dpt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        req_last,
   input  wire stat_type    stat,
   output cmd_type          cmd,
   output logic             busy,
   output logic [IdxW-1:0]  load_idx,
   output logic             overflow_seen
);
   state_type       state_ff, state_in;
   logic [TotW-1:0] total_ff, total_in;
   logic            ovf_ff, ovf_in;
   logic [IdxW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CntW-1:0] c_ff, c_in;
   logic [1:0]      ph_ff, ph_in;
   logic [1:0]      ph_last;
   logic            exec;
   logic [IdxW-1:0] last_idx;
   logic            acc;

   assign acc           = start && !busy;
   assign load_idx      = total_ff[IdxW-1:0];
   assign overflow_seen = ovf_ff;
   assign last_idx      = IdxW'(total_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         total_ff <= '0;
         ovf_ff   <= 1'b0;
         ph_ff    <= '0;
         i_ff <= '0; j_ff <= '0; k_ff <= '0; c_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
         ph_ff    <= ph_in;
         i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; c_ff <= c_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      ovf_in   = ovf_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; c_in = c_ff;
      cmd = '0;
      cmd.i = i_ff; cmd.j = j_ff; cmd.c = c_ff; cmd.k = k_ff;
      busy = (state_ff != ST_LOAD);
      // each step reads in its early cycles and acts in its last one
      ph_last = ((state_ff == ST_PAIR) || (state_ff == ST_VISIT)) ? 2'd2 : 2'd1;
      exec    = (ph_ff == ph_last);
      ph_in   = exec ? 2'd0 : ph_ff + 2'd1;
      unique case (state_ff)
         ST_LOAD: begin
            ph_in = '0;
            if (acc) begin
               if (total_ff < TotW'(MaxPoints)) begin
                  cmd.load = 1'b1;
                  total_in = total_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  state_in = ST_PAIR;
                  i_in = '0; j_in = '0;
                  cmd.clr_nbr = 1'b1;
               end
            end
         end
         ST_PAIR: begin
            if (exec) begin
               cmd.pair = 1'b1;
               if (j_ff == last_idx) begin
                  cmd.pair_end = 1'b1;
                  cmd.clr_nbr  = 1'b1;
                  j_in = '0;
                  if (i_ff == last_idx) begin
                     state_in = ST_SORT;
                     i_in = '0; c_in = CountMax;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         ST_SORT: begin
            if (exec) begin
               cmd.sort = 1'b1;
               if (i_ff == last_idx) begin
                  i_in = '0;
                  if (c_ff == '0) begin
                     state_in = ST_VISIT;
                     k_in = '0;
                  end else begin
                     c_in = c_ff - 1'b1;
                  end
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         ST_VISIT: begin
            if (exec) begin
               cmd.visit = 1'b1;
               if (stat.remove) begin
                  state_in = ST_DEC;
                  j_in = '0;
               end else if (k_ff == last_idx) begin
                  state_in = ST_EMIT;
                  i_in = '0;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         ST_DEC: begin
            if (exec) begin
               cmd.dec = 1'b1;
               if (j_ff == last_idx) begin
                  if (k_ff == last_idx) begin
                     state_in = ST_EMIT;
                     i_in = '0;
                  end else begin
                     state_in = ST_VISIT;
                     k_in = k_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (exec) begin
               cmd.emit = 1'b1;
               if (i_ff == last_idx) begin
                  cmd.emit_last = 1'b1;
                  state_in = ST_LOAD;
                  total_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   ap_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TotW'(MaxPoints)) else $error("point total beyond capacity");
   ap_busy_run: assert property (@(posedge clock) disable iff (reset)
      (acc && req_last) |=> busy) else $error("run did not start");
   ap_emit_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_last |=> (total_ff == '0 && !ovf_ff)) else $error("set not cleared");
   ap_phase_bound: assert property (@(posedge clock) disable iff (reset)
      ph_ff <= 2'd2) else $error("step phase out of range");
endmodule
`default_nettype wire

// ===== sv/density_point_thinning_core.sv =====
// Loads up to 64 points (a start per point, busy low while loading); the
// point flagged last starts a run. For n stored points the run checks the
// distance of every ordered pair, one pair at a time (read, square,
// compare), then sorts by count from 63 down to 0, visits the points in
// that order, decrements the neighbours of each removed point, and emits
// all n points. rsp_valid marks each result for one cycle and cannot be
// held off. Extra points are dropped and reported by rsp_overflow.
`default_nettype none
module density_point_thinning_core import dpt_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic signed [CoordW-1:0] req_x,
   input  wire logic signed [CoordW-1:0] req_y,
   input  wire logic signed [CoordW-1:0] req_z,
   input  wire logic [LayerW-1:0]        req_layer,
   input  wire logic                     req_last,
   input  wire logic                     csr_we,
   input  wire logic [CsrIdxW-1:0]       csr_index,
   input  wire logic [CsrDataW-1:0]      csr_wdata,
   output logic                          rsp_valid,
   output logic signed [CoordW-1:0]      rsp_out_x,
   output logic signed [CoordW-1:0]      rsp_out_y,
   output logic signed [CoordW-1:0]      rsp_out_z,
   output logic [LayerW-1:0]             rsp_out_layer,
   output logic                          rsp_keep,
   output logic                          rsp_overflow,
   output logic                          rsp_out_last
);
   logic [RadW-1:0] radius_ff;
   logic [CntW-1:0] maxcnt_ff;
   cmd_type         cmd;
   stat_type        stat;
   logic [IdxW-1:0] load_idx;
   logic            ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RadW'(300);
         maxcnt_ff <= CntW'(3);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIUS: radius_ff <= csr_wdata[RadW-1:0];
            CSR_MAXCNT: maxcnt_ff <= csr_wdata[CntW-1:0];
            default: ;
         endcase
      end
   end

   dpt_ctrl u_ctrl (
      .clock, .reset, .start, .req_last, .stat, .cmd, .busy, .load_idx,
      .overflow_seen(ovf)
   );

   dpt_datapath u_dp (
      .clock, .reset, .cmd, .stat, .load_idx, .req_x, .req_y, .req_z, .req_layer,
      .radius(radius_ff), .max_cnt(maxcnt_ff), .overflow_seen(ovf),
      .rsp_valid, .rsp_out_x, .rsp_out_y, .rsp_out_z, .rsp_out_layer,
      .rsp_keep, .rsp_overflow, .rsp_out_last
   );
endmodule
`default_nettype wire
